// ===== sv/mrq_pkg.sv =====
// Shared types, codes and defaults for the message ring queue.
package mrq_pkg;

    localparam int SLOTS_DEF     = 16;
    localparam int MAX_BYTES_DEF = 64;

    // config register indexes
    localparam logic CFG_MAX_MESSAGES = 1'b0;
    localparam logic CFG_SLOT_BYTES   = 1'b1;

    localparam logic [4:0] MAX_MESSAGES_RST = 5'd16;
    localparam logic [6:0] SLOT_BYTES_RST   = 7'd64;

    // input action codes
    localparam logic ACT_ENQ = 1'b0;
    localparam logic ACT_DEQ = 1'b1;

    // result kinds
    localparam logic KIND_ACK = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    // status codes
    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_FULL  = 2'd1;
    localparam logic [1:0] STS_EMPTY = 2'd2;
    localparam logic [1:0] STS_LONG  = 2'd3;

    // queue fill states
    localparam logic [1:0] FILL_EMPTY = 2'd0;
    localparam logic [1:0] FILL_AVAIL = 2'd1;
    localparam logic [1:0] FILL_FULL  = 2'd2;

    typedef struct packed {
        logic enq;       // enqueue word accepted
        logic deq;       // dequeue request accepted
        logic len_load;  // stored length is on the length memory output
        logic stream;    // message bytes being streamed out
    } cmd_t;

    typedef struct packed {
        logic empty;     // queue holds no message
        logic out_free;  // output register can take a word this cycle
        logic done;      // final byte of the message loaded into output
    } sts_t;

endpackage

// ===== sv/mrq_ctrl.sv =====
// Controller state machine: input handshake and dequeue sequencing.
module mrq_ctrl
    import mrq_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  logic s_tuser,    // action
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_LEN    = 2'd1;
    localparam logic [1:0] ST_STREAM = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    assign s_tready = (state_reg == ST_IDLE) && sts.out_free;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        cmd.enq      = accept && (s_tuser == ACT_ENQ);
        cmd.deq      = accept && (s_tuser == ACT_DEQ);
        cmd.len_load = (state_reg == ST_LEN);
        cmd.stream   = (state_reg == ST_STREAM);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.deq && !sts.empty) begin
                    state_next = ST_LEN;
                end
            end
            ST_LEN: begin
                state_next = ST_STREAM;
            end
            ST_STREAM: begin
                if (sts.done) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sv/mrq_datapath.sv =====
// Datapath: config registers, indexes, message and length memories, output register.
module mrq_datapath
    import mrq_pkg::*;
#(
    parameter int SLOTS     = SLOTS_DEF,
    parameter int MAX_BYTES = MAX_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [6:0]  cfg_wdata,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    input  cmd_t        cmd,
    output sts_t        sts,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,
    output logic        m_tuser,
    output logic        m_tlast
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int BW    = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam int AW    = IDX_W + BW;
    localparam int SC_W  = IDX_W + 1;
    localparam int NW    = (SC_W > 5) ? SC_W : 5;

    localparam logic [NW-1:0] SLOTS_N   = NW'(SLOTS);
    localparam logic [6:0]    MAX_B7    = 7'(MAX_BYTES);
    localparam logic [6:0]    CNT_SAT   = 7'd127;

    logic [7:0] msg_mem [0:(1 << AW)-1];
    logic [6:0] len_mem [0:(1 << IDX_W)-1];

    logic [4:0]       max_msg_reg;
    logic [6:0]       slot_bytes_reg;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0] wr_idx_reg, wr_idx_next;
    logic [1:0]       fill_reg, fill_next;
    logic [6:0]       in_cnt_reg, in_cnt_next;
    logic [1:0]       in_err_reg, in_err_next;
    logic [IDX_W-1:0] slot_reg;
    logic [6:0]       len_reg;
    logic [6:0]       issue_cnt_reg, issue_cnt_next;
    logic [6:0]       send_cnt_reg, send_cnt_next;
    logic             dv_reg, dv_next;
    logic [6:0]       len_q;
    logic [7:0]       byte_q;

    logic        out_valid_reg, out_valid_next;
    logic        out_kind_reg, out_kind_next;
    logic [1:0]  out_status_reg, out_status_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic [6:0]  out_len_reg, out_len_next;
    logic        out_last_reg, out_last_next;
    logic [1:0]  out_fill_reg, out_fill_next;

    logic [NW-1:0]    eff_slots;
    logic [6:0]       eff_bytes;
    logic             out_free;
    logic [1:0]       enq_err;
    logic [6:0]       cnt_inc;
    logic             msg_we;
    logic             len_we;
    logic [IDX_W-1:0] wr_adv;
    logic [IDX_W-1:0] rd_adv;
    logic             out_load;
    logic             byte_load;
    logic             byte_issue;
    logic             byte_last;

    always_comb begin
        if (max_msg_reg == 5'd0) begin
            eff_slots = NW'(1);
        end else if (NW'(max_msg_reg) > SLOTS_N) begin
            eff_slots = SLOTS_N;
        end else begin
            eff_slots = NW'(max_msg_reg);
        end
        if (slot_bytes_reg == 7'd0) begin
            eff_bytes = 7'd1;
        end else if (slot_bytes_reg > MAX_B7) begin
            eff_bytes = MAX_B7;
        end else begin
            eff_bytes = slot_bytes_reg;
        end
    end

    // index advance wraps once it reaches the slot count in use
    assign wr_adv = ((NW'(wr_idx_reg) + NW'(1)) >= eff_slots) ? '0 : wr_idx_reg + 1'b1;
    assign rd_adv = ((NW'(rd_idx_reg) + NW'(1)) >= eff_slots) ? '0 : rd_idx_reg + 1'b1;

    assign out_free     = !out_valid_reg || m_tready;
    assign byte_load    = cmd.stream && dv_reg && out_free;
    assign byte_issue   = cmd.stream && (issue_cnt_reg < len_reg) && (!dv_reg || byte_load);
    assign byte_last    = ((send_cnt_reg + 7'd1) >= len_reg);

    always_comb begin
        sts.empty    = (fill_reg == FILL_EMPTY);
        sts.out_free = out_free;
        sts.done     = byte_load && byte_last;
    end

    always_comb begin
        enq_err = in_err_reg;
        msg_we  = 1'b0;
        if (in_err_reg == STS_OK) begin
            if (fill_reg == FILL_FULL) begin
                enq_err = STS_FULL;
            end else if (in_cnt_reg >= eff_bytes) begin
                enq_err = STS_LONG;
            end else begin
                msg_we = cmd.enq;
            end
        end
        cnt_inc = (in_cnt_reg == CNT_SAT) ? in_cnt_reg : in_cnt_reg + 7'd1;
    end

    always_comb begin
        rd_idx_next     = rd_idx_reg;
        wr_idx_next     = wr_idx_reg;
        fill_next       = fill_reg;
        in_cnt_next     = in_cnt_reg;
        in_err_next     = in_err_reg;
        issue_cnt_next  = issue_cnt_reg;
        send_cnt_next   = send_cnt_reg;
        dv_next         = dv_reg;
        len_we          = 1'b0;
        out_load        = 1'b0;
        out_kind_next   = out_kind_reg;
        out_status_next = out_status_reg;
        out_byte_next   = out_byte_reg;
        out_len_next    = out_len_reg;
        out_last_next   = out_last_reg;
        out_fill_next   = out_fill_reg;

        if (cmd.enq) begin
            if (in_last) begin
                if (enq_err == STS_OK) begin
                    len_we      = 1'b1;
                    wr_idx_next = wr_adv;
                    fill_next   = (rd_idx_reg == wr_adv) ? FILL_FULL : FILL_AVAIL;
                end
                in_cnt_next     = '0;
                in_err_next     = STS_OK;
                out_load        = 1'b1;
                out_kind_next   = KIND_ACK;
                out_status_next = enq_err;
                out_byte_next   = '0;
                out_len_next    = cnt_inc;
                out_last_next   = 1'b1;
                out_fill_next   = (enq_err == STS_OK)
                                  ? ((rd_idx_reg == wr_adv) ? FILL_FULL : FILL_AVAIL)
                                  : fill_reg;
            end else begin
                in_cnt_next = cnt_inc;
                in_err_next = enq_err;
            end
        end

        if (cmd.deq) begin
            if (fill_reg == FILL_EMPTY) begin
                out_load        = 1'b1;
                out_kind_next   = KIND_DEQ;
                out_status_next = STS_EMPTY;
                out_byte_next   = '0;
                out_len_next    = '0;
                out_last_next   = 1'b1;
                out_fill_next   = FILL_EMPTY;
            end else begin
                rd_idx_next    = rd_adv;
                fill_next      = (wr_idx_reg == rd_adv) ? FILL_EMPTY : FILL_AVAIL;
                issue_cnt_next = '0;
                send_cnt_next  = '0;
                dv_next        = 1'b0;
            end
        end

        if (byte_issue) begin
            issue_cnt_next = issue_cnt_reg + 7'd1;
            dv_next        = 1'b1;
        end else if (byte_load) begin
            dv_next = 1'b0;
        end

        if (byte_load) begin
            send_cnt_next   = send_cnt_reg + 7'd1;
            out_load        = 1'b1;
            out_kind_next   = KIND_DEQ;
            out_status_next = STS_OK;
            out_byte_next   = byte_q;
            out_len_next    = len_reg;
            out_last_next   = byte_last;
            out_fill_next   = fill_reg;
        end

        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // message memory: one write port for enqueue, one registered read port for streaming
    always_ff @(posedge aclk) begin
        if (msg_we) begin
            msg_mem[{wr_idx_reg, in_cnt_reg[BW-1:0]}] <= in_byte;
        end
        if (byte_issue) begin
            byte_q <= msg_mem[{slot_reg, issue_cnt_reg[BW-1:0]}];
        end
    end

    always_ff @(posedge aclk) begin
        if (len_we) begin
            len_mem[wr_idx_reg] <= cnt_inc;
        end
        if (cmd.deq) begin
            len_q <= len_mem[rd_idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.deq) begin
            slot_reg <= rd_idx_reg;
        end
        if (cmd.len_load) begin
            len_reg <= (len_q > MAX_B7) ? MAX_B7 : len_q;
        end
        issue_cnt_reg  <= issue_cnt_next;
        send_cnt_reg   <= send_cnt_next;
        out_kind_reg   <= out_kind_next;
        out_status_reg <= out_status_next;
        out_byte_reg   <= out_byte_next;
        out_len_reg    <= out_len_next;
        out_last_reg   <= out_last_next;
        out_fill_reg   <= out_fill_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_msg_reg    <= MAX_MESSAGES_RST;
            slot_bytes_reg <= SLOT_BYTES_RST;
            rd_idx_reg     <= '0;
            wr_idx_reg     <= '0;
            fill_reg       <= FILL_EMPTY;
            in_cnt_reg     <= '0;
            in_err_reg     <= STS_OK;
            dv_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    CFG_MAX_MESSAGES: max_msg_reg    <= cfg_wdata[4:0];
                    CFG_SLOT_BYTES:   slot_bytes_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            rd_idx_reg    <= rd_idx_next;
            wr_idx_reg    <= wr_idx_next;
            fill_reg      <= fill_next;
            in_cnt_reg    <= in_cnt_next;
            in_err_reg    <= in_err_next;
            dv_reg        <= dv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {5'd0, out_fill_reg, out_len_reg, out_byte_reg, out_status_reg};

endmodule

// ===== sv/message_ring_queue_core.sv =====
// Enqueue word: one per cycle while idle and the output is free; ack is visible
//   the cycle after the final byte is taken.
// Dequeue: length memory read, then length register, then byte memory read; then
//   one byte per cycle while output is free; next word taken after the last byte.
// Reset (aresetn, synchronous): clears indexes, input count and fill state, sets
//   config to defaults; message and length memories keep their contents.
module message_ring_queue_core
    import mrq_pkg::*;
#(
    parameter int SLOTS     = SLOTS_DEF,
    parameter int MAX_BYTES = MAX_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [6:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tuser,   // action
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // status, out_byte, message_length, queue_state
    output logic        m_tuser,   // result_kind
    output logic        m_tlast    // last
);

    cmd_t cmd;
    sts_t sts;

    mrq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    mrq_datapath #(
        .SLOTS     (SLOTS),
        .MAX_BYTES (MAX_BYTES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== tb/sv/tb_message_ring_queue_core.sv =====
// Self-checking bench for the message ring queue: scoreboard plus random traffic.
module tb_message_ring_queue_core
    import mrq_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUN_LIMIT = 500000;

    typedef struct {
        logic       action;
        logic [7:0] data;
        logic       last;
    } op_t;

    typedef struct {
        logic       kind;
        logic [1:0] status;
        logic [7:0] data;
        logic [6:0] len;
        logic       last;
        logic [1:0] qstate;
    } reply_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_addr  = 1'b0;
    logic [6:0]  cfg_wdata = 7'd0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'd0;   // data_byte
    logic        s_tuser   = 1'b0;   // action
    logic        s_tlast   = 1'b0;   // last_byte
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;            // status, out_byte, message_length, queue_state
    logic        m_tuser;            // result_kind
    logic        m_tlast;            // last

    message_ring_queue_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // mirror of the queue contents and registers
    logic [7:0] byte_mem [SLOTS_DEF][MAX_BYTES_DEF];
    logic [6:0] len_mem  [SLOTS_DEF];
    int         rd_idx = 0;
    int         wr_idx = 0;
    logic [1:0] fill = FILL_EMPTY;
    int         in_count = 0;
    logic [1:0] in_err = STS_OK;
    logic [4:0] max_msgs_reg = MAX_MESSAGES_RST;
    logic [6:0] slot_bytes_reg = SLOT_BYTES_RST;

    op_t    tx_words[$];
    reply_t owed[$];
    op_t    cur_op;
    reply_t want;
    int     send_idle_pct = 0;
    int     stall_pct = 0;
    int     tx_count = 0;
    int     rx_count = 0;
    int     fails = 0;
    int     cycles = 0;

    function automatic int active_slots();
        if (max_msgs_reg < 1) return 1;
        if (max_msgs_reg > SLOTS_DEF) return SLOTS_DEF;
        return max_msgs_reg;
    endfunction

    function automatic int active_bytes();
        if (slot_bytes_reg < 1) return 1;
        if (slot_bytes_reg > MAX_BYTES_DEF) return MAX_BYTES_DEF;
        return slot_bytes_reg;
    endfunction

    function automatic int next_index(int idx);
        return (idx + 1 >= active_slots()) ? 0 : idx + 1;
    endfunction

    // Applies one accepted word to the mirror and queues the results it owes.
    task automatic apply_queue_op(op_t op);
        int slot;
        int n;
        if (op.action == ACT_ENQ) begin
            // first error of a message sticks
            if (in_err == STS_OK) begin
                if (fill == FILL_FULL) in_err = STS_FULL;
                else if (in_count >= active_bytes()) in_err = STS_LONG;
                else byte_mem[wr_idx][in_count] = op.data;
            end
            if (in_count < 127) in_count++;
            if (op.last) begin
                if (in_err == STS_OK) begin
                    len_mem[wr_idx] = 7'(in_count);
                    wr_idx = next_index(wr_idx);
                    fill = (rd_idx == wr_idx) ? FILL_FULL : FILL_AVAIL;
                end
                owed.push_back(reply_t'{KIND_ACK, in_err, 8'd0, 7'(in_count), 1'b1, fill});
                in_count = 0;
                in_err = STS_OK;
            end
        end else if (fill == FILL_EMPTY) begin
            owed.push_back(reply_t'{KIND_DEQ, STS_EMPTY, 8'd0, 7'd0, 1'b1, FILL_EMPTY});
        end else begin
            slot = rd_idx;
            n = len_mem[slot];
            rd_idx = next_index(rd_idx);
            fill = (wr_idx == rd_idx) ? FILL_EMPTY : FILL_AVAIL;
            if (n == 0)
                owed.push_back(reply_t'{KIND_DEQ, STS_OK, 8'd0, 7'd0, 1'b1, fill});
            for (int i = 0; i < n; i++)
                owed.push_back(reply_t'{KIND_DEQ, STS_OK, byte_mem[slot][i], 7'(n),
                                        i == n - 1, fill});
        end
    endtask

    task automatic check_field(string name, int exp_val, int got_val);
        if (exp_val != got_val) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_val, got_val);
            fails++;
        end
    endtask

    task automatic push_op(logic act, logic [7:0] d, logic l);
        tx_words.push_back(op_t'{act, d, l});
    endtask

    task automatic add_deq();
        push_op(ACT_DEQ, 8'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    task automatic add_msg(int len);
        for (int i = 0; i < len; i++)
            push_op(ACT_ENQ, 8'($urandom_range(255)), i == len - 1);
    endtask

    // Waits until every word went out and every result came back, then lets
    // the core settle.
    task automatic wait_idle();
        do @(negedge aclk);
        while (tx_words.size() != 0 || s_tvalid || owed.size() != 0);
        repeat (12) @(negedge aclk);
    endtask

    task automatic cfg_set(logic [4:0] m, logic [6:0] b);
        max_msgs_reg = m;
        slot_bytes_reg = b;
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= CFG_MAX_MESSAGES;
        cfg_wdata <= {2'b00, m};
        @(posedge aclk);
        cfg_addr <= CFG_SLOT_BYTES;
        cfg_wdata <= b;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Mostly well-formed messages and dequeues, some over-long ones and noise.
    task automatic gen_traffic(int n);
        int added;
        int sel;
        int len;
        int cap;
        added = 0;
        while (added < n) begin
            sel = $urandom_range(99);
            cap = (active_bytes() < 6) ? active_bytes() : 6;
            if (sel < 32) begin
                add_deq();
                added++;
            end else if (sel < 80 || (sel < 92 && active_bytes() > 16)) begin
                len = ($urandom_range(7) == 0) ? active_bytes() : $urandom_range(cap, 1);
                add_msg(len);
                added += len;
            end else if (sel < 92) begin
                len = active_bytes() + $urandom_range(3, 1);
                add_msg(len);
                added += len;
            end else begin
                push_op(1'($urandom_range(1)), 8'($urandom_range(255)),
                        1'($urandom_range(1)));
                added++;
            end
        end
    endtask

    // One setting: traffic, a full drain-out pause, more traffic, then empty
    // the queue so the next register write finds it idle.
    task automatic run_phase(logic [4:0] m, logic [6:0] b, int idle, int stall, int n);
        cfg_set(m, b);
        send_idle_pct = idle;
        stall_pct = stall;
        repeat (2) begin
            gen_traffic(n / 2);
            wait_idle();
        end
        add_msg(1);   // closes any message left open by noise
        repeat (active_slots() + 1) add_deq();
        wait_idle();
    endtask

    initial begin
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > RUN_LIMIT) begin
            $display("tb_message_ring_queue_core: FAIL");
            $finish;
        end
    end

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                apply_queue_op(cur_op);
                tx_count++;
            end
            if (!s_tvalid || s_tready) begin
                if (tx_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_op = tx_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= cur_op.action;
                    s_tdata <= cur_op.data;
                    s_tlast <= cur_op.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
        if (aresetn && m_tvalid && m_tready) begin
            if (owed.size() == 0) begin
                $error("result word with nothing outstanding: tdata %h", m_tdata);
                fails++;
            end else begin
                want = owed.pop_front();
                check_field("result_kind", want.kind, m_tuser);
                check_field("status", want.status, m_tdata[1:0]);
                check_field("out_byte", want.data, m_tdata[9:2]);
                check_field("message_length", want.len, m_tdata[16:10]);
                check_field("last", want.last, m_tlast);
                check_field("queue_state", want.qstate, m_tdata[18:17]);
                rx_count++;
            end
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // single slot of two bytes: full, sticky full error, too long
        cfg_set(5'd1, 7'd2);
        push_op(ACT_ENQ, 8'h12, 1'b0);
        push_op(ACT_ENQ, 8'h34, 1'b1);
        push_op(ACT_ENQ, 8'h56, 1'b1);
        push_op(ACT_ENQ, 8'hAA, 1'b0);
        push_op(ACT_ENQ, 8'hBB, 1'b0);
        push_op(ACT_ENQ, 8'hCC, 1'b1);
        push_op(ACT_DEQ, 8'hFF, 1'b1);
        push_op(ACT_ENQ, 8'h01, 1'b0);
        push_op(ACT_ENQ, 8'h02, 1'b0);
        push_op(ACT_ENQ, 8'h03, 1'b1);
        push_op(ACT_DEQ, 8'h00, 1'b0);
        push_op(ACT_ENQ, 8'h80, 1'b1);
        push_op(ACT_DEQ, 8'h7F, 1'b0);
        wait_idle();

        // full size: empty dequeue, byte extremes, multi-byte message
        cfg_set(5'd16, 7'd64);
        push_op(ACT_DEQ, 8'h00, 1'b0);
        push_op(ACT_ENQ, 8'h00, 1'b1);
        push_op(ACT_ENQ, 8'hFF, 1'b1);
        push_op(ACT_ENQ, 8'hA5, 1'b0);
        push_op(ACT_ENQ, 8'h5A, 1'b0);
        push_op(ACT_ENQ, 8'hC3, 1'b1);
        repeat (3) push_op(ACT_DEQ, 8'hFF, 1'b1);
        push_op(ACT_DEQ, 8'h55, 1'b1);
        wait_idle();

        run_phase(5'd16, 7'd64, 0, 0, 12);
        run_phase(5'd4, 7'd8, 83, 0, 12);
        run_phase(5'd2, 7'd3, 0, 83, 12);
        run_phase(5'd0, 7'd127, 19, 19, 12);
        run_phase(5'd31, 7'd0, 0, 0, 12);

        $display("Sent %0d words, checked %0d results across 7 register settings",
                 tx_count, rx_count);
        $display("(incl. saturating register values) under sender gaps and receiver stalls.");
        if (fails == 0) begin
            $display("tb_message_ring_queue_core: PASS");
        end else begin
            $display("tb_message_ring_queue_core: FAIL");
        end
        $finish;
    end

endmodule
